### design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the lexer checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SLEX_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SLEX_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/slex_pkg.sv
// ---------------------------------------------------------------------------
// Lexer package
// Types, codes and keyword tables shared by the lexer core and its checker.
// ---------------------------------------------------------------------------
package slex_pkg;

  localparam int KEYWORD_CHARS = 8;
  localparam int KW_IDX_W      = $clog2(KEYWORD_CHARS);
  localparam int KW_COUNT      = 6;
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_W    = 2;
  localparam int FIFO_CNT_W    = 3;

  // Token classes.
  localparam logic [2:0] CLS_KEYWORD = 3'd0;
  localparam logic [2:0] CLS_IDENT   = 3'd1;
  localparam logic [2:0] CLS_NUMBER  = 3'd2;
  localparam logic [2:0] CLS_STRING  = 3'd3;
  localparam logic [2:0] CLS_PUNCT   = 3'd4;
  localparam logic [2:0] CLS_END     = 3'd5;
  localparam logic [2:0] CLS_UNTERM  = 3'd6;

  // Character codes.
  localparam logic [7:0] CH_EOT   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  typedef enum logic [3:0] {
    MODE_IDLE   = 4'b0001,
    MODE_IDENT  = 4'b0010,
    MODE_NUMBER = 4'b0100,
    MODE_STRING = 4'b1000
  } mode_t;

  typedef logic [KEYWORD_CHARS-1:0][7:0] word_t;

  typedef struct packed {
    logic [2:0]  cls;
    logic [7:0]  value;
    logic [15:0] row;
    logic [15:0] col;
    logic [31:0] offset;
    logic [15:0] len;
    logic        last;
  } result_t;

  // Keyword text, right-justified: the first character sits highest.
  localparam logic [63:0] KW_STR [KW_COUNT] = '{
    64'("for"), 64'("if"), 64'("else"), 64'("let"), 64'("const"), 64'("function")
  };
  localparam int KW_LEN [KW_COUNT] = '{3, 2, 4, 3, 5, 8};

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    sat_inc = (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // Returns {hit, index}; a later keyword wins, as there is no overlap anyway.
  function automatic logic [3:0] kw_match(input word_t wb, input logic [15:0] len);
    logic       same;
    logic [3:0] res;
    res = 4'b0;
    for (int k = 0; k < KW_COUNT; k++) begin
      same = (len == 16'(KW_LEN[k]));
      for (int i = 0; i < KEYWORD_CHARS; i++) begin
        if (i < KW_LEN[k]) begin
          if (wb[i] != KW_STR[k][8*(KW_LEN[k]-1-i) +: 8]) begin
            same = 1'b0;
          end
        end
      end
      if (same) begin
        res = {1'b1, 3'(k)};
      end
    end
    kw_match = res;
  endfunction

endpackage

### design/source_lexer_with_keywords_core.sv
// ---------------------------------------------------------------------------
// Source lexer with keyword recognition
// Splits a byte stream into identifier, keyword, number, string and punctuation
// tokens, plus end and unterminated-string tokens, with their row, column, offset and length.
// ---------------------------------------------------------------------------
//
//   channel | handshake               | payload
//   --------+-------------------------+-----------------------------------------
//   input   | in_valid / in_stall     | ch
//   output  | out_valid / out_stall   | token_class, token_value, start_row,
//           |                         | start_col, start_offset, token_length, last
//
// One byte is taken per cycle while in_stall is low. Each byte is classified and
// the lexer state is updated in the cycle it is accepted; the zero, one or two
// tokens it finishes are written into a four-entry result queue, which the output
// side drains at one item per cycle while out_stall is low. The input stalls while
// fewer than two queue entries are free, so the sustained rate is one byte per
// cycle unless the text produces more tokens than the output can take. Reset (rst,
// synchronous) returns the lexer to row 1, column 1, offset 0 and empties the queue.
module source_lexer_with_keywords_core (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  ch,
  input  logic        in_valid,
  output logic        in_stall,
  output logic [2:0]  token_class,
  output logic [7:0]  token_value,
  output logic [15:0] start_row,
  output logic [15:0] start_col,
  output logic [31:0] start_offset,
  output logic [15:0] token_length,
  output logic        last,
  output logic        out_valid,
  input  logic        out_stall
);

  // Lexer state.
  slex_pkg::mode_t mode, mode_next;
  logic [15:0]     cur_row, cur_row_next;
  logic [15:0]     cur_col, cur_col_next;
  logic [31:0]     cur_off, cur_off_next;
  logic [15:0]     tok_row, tok_row_next;
  logic [15:0]     tok_col, tok_col_next;
  logic [31:0]     tok_off, tok_off_next;
  logic [15:0]     tok_len, tok_len_next;
  slex_pkg::word_t word_buf, word_buf_next;

  // Result queue.
  slex_pkg::result_t                    q [slex_pkg::FIFO_DEPTH];
  logic [slex_pkg::FIFO_PTR_W-1:0]      wr_ptr, rd_ptr;
  logic [slex_pkg::FIFO_CNT_W-1:0]      count;

  slex_pkg::result_t res0, res1, idle_res;
  logic [1:0]        n_res;
  logic              go_idle, idle_hit, restart_now;
  logic              in_acc, pop;
  logic              is_alpha, is_digit, is_space, is_start, is_cont;
  logic [15:0]       adv_row, adv_col;
  logic [31:0]       adv_off;
  logic [3:0]        kw;

  assign in_stall = (count > slex_pkg::FIFO_CNT_W'(slex_pkg::FIFO_DEPTH - 2));
  assign in_acc   = in_valid && !in_stall;
  assign out_valid = (count != '0);
  assign pop      = out_valid && !out_stall;

  assign token_class  = q[rd_ptr].cls;
  assign token_value  = q[rd_ptr].value;
  assign start_row    = q[rd_ptr].row;
  assign start_col    = q[rd_ptr].col;
  assign start_offset = q[rd_ptr].offset;
  assign token_length = q[rd_ptr].len;
  assign last         = q[rd_ptr].last;

  // Character classes.
  assign is_alpha = (ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A);
  assign is_digit = (ch >= 8'h30 && ch <= 8'h39);
  assign is_space = (ch == 8'h20) || (ch >= 8'h09 && ch <= 8'h0D);
  assign is_start = is_alpha || (ch == slex_pkg::CH_UNDER);
  assign is_cont  = is_start || is_digit;

  // Position after consuming this byte: a newline moves to the next row.
  assign adv_row = (ch == slex_pkg::CH_NL) ? slex_pkg::sat_inc(cur_row) : cur_row;
  assign adv_col = (ch == slex_pkg::CH_NL) ? 16'd1 : slex_pkg::sat_inc(cur_col);
  assign adv_off = cur_off + 32'd1;

  assign kw = slex_pkg::kw_match(word_buf, tok_len);

  always_comb begin
    mode_next     = mode;
    cur_row_next  = cur_row;
    cur_col_next  = cur_col;
    cur_off_next  = cur_off;
    tok_row_next  = tok_row;
    tok_col_next  = tok_col;
    tok_off_next  = tok_off;
    tok_len_next  = tok_len;
    word_buf_next = word_buf;
    res0          = '0;
    res1          = '0;
    idle_res      = '0;
    n_res         = 2'd0;
    go_idle       = 1'b0;
    idle_hit      = 1'b0;
    restart_now   = 1'b0;

    unique case (mode)
      slex_pkg::MODE_IDENT: begin
        if (is_cont) begin
          if (tok_len < 16'(slex_pkg::KEYWORD_CHARS)) begin
            word_buf_next[tok_len[slex_pkg::KW_IDX_W-1:0]] = ch;
          end
          tok_len_next = slex_pkg::sat_inc(tok_len);
          cur_row_next = adv_row;
          cur_col_next = adv_col;
          cur_off_next = adv_off;
        end else begin
          res0.cls    = kw[3] ? slex_pkg::CLS_KEYWORD : slex_pkg::CLS_IDENT;
          res0.value  = kw[3] ? {5'd0, kw[2:0]} : 8'd0;
          res0.row    = tok_row;
          res0.col    = tok_col;
          res0.offset = tok_off;
          res0.len    = tok_len;
          n_res       = 2'd1;
          go_idle     = 1'b1;
        end
      end
      slex_pkg::MODE_NUMBER: begin
        if (is_digit) begin
          tok_len_next = slex_pkg::sat_inc(tok_len);
          cur_row_next = adv_row;
          cur_col_next = adv_col;
          cur_off_next = adv_off;
        end else begin
          res0.cls    = slex_pkg::CLS_NUMBER;
          res0.row    = tok_row;
          res0.col    = tok_col;
          res0.offset = tok_off;
          res0.len    = tok_len;
          n_res       = 2'd1;
          go_idle     = 1'b1;
        end
      end
      slex_pkg::MODE_STRING: begin
        res0.row    = tok_row;
        res0.col    = tok_col;
        res0.offset = tok_off;
        res0.len    = tok_len;
        priority if (ch == slex_pkg::CH_QUOTE) begin
          res0.cls     = slex_pkg::CLS_STRING;
          n_res        = 2'd1;
          mode_next    = slex_pkg::MODE_IDLE;
          cur_row_next = adv_row;
          cur_col_next = adv_col;
          cur_off_next = adv_off;
        end else if (ch == slex_pkg::CH_EOT) begin
          // Text ended inside a string: report it, then the end token.
          res0.cls    = slex_pkg::CLS_UNTERM;
          res1.cls    = slex_pkg::CLS_END;
          res1.row    = cur_row;
          res1.col    = cur_col;
          res1.offset = cur_off;
          n_res       = 2'd2;
          restart_now = 1'b1;
        end else begin
          tok_len_next = slex_pkg::sat_inc(tok_len);
          cur_row_next = adv_row;
          cur_col_next = adv_col;
          cur_off_next = adv_off;
        end
      end
      slex_pkg::MODE_IDLE: begin
        go_idle = 1'b1;
      end
      default: begin
        mode_next = slex_pkg::MODE_IDLE;
      end
    endcase

    // A byte seen in idle, or the byte that ended an identifier or number.
    if (go_idle) begin
      mode_next       = slex_pkg::MODE_IDLE;
      idle_res.row    = cur_row;
      idle_res.col    = cur_col;
      idle_res.offset = cur_off;
      priority if (ch == slex_pkg::CH_EOT) begin
        idle_res.cls = slex_pkg::CLS_END;
        idle_hit     = 1'b1;
        restart_now  = 1'b1;
      end else if (is_start || is_digit || ch == slex_pkg::CH_QUOTE) begin
        tok_row_next = cur_row;
        tok_col_next = cur_col;
        tok_off_next = cur_off;
        tok_len_next = 16'd1;
        if (is_start) begin
          mode_next        = slex_pkg::MODE_IDENT;
          word_buf_next[0] = ch;
        end else if (is_digit) begin
          mode_next = slex_pkg::MODE_NUMBER;
        end else begin
          // Strings start their text just past the opening quote.
          mode_next    = slex_pkg::MODE_STRING;
          tok_off_next = adv_off;
          tok_len_next = 16'd0;
        end
      end else if (!is_space) begin
        idle_res.cls   = slex_pkg::CLS_PUNCT;
        idle_res.value = ch;
        idle_res.len   = 16'd1;
        idle_hit       = 1'b1;
      end
      if (ch != slex_pkg::CH_EOT) begin
        cur_row_next = adv_row;
        cur_col_next = adv_col;
        cur_off_next = adv_off;
      end
      if (idle_hit) begin
        if (n_res == 2'd0) begin
          res0 = idle_res;
        end else begin
          res1 = idle_res;
        end
        n_res = n_res + 2'd1;
      end
    end

    if (restart_now) begin
      mode_next    = slex_pkg::MODE_IDLE;
      cur_row_next = 16'd1;
      cur_col_next = 16'd1;
      cur_off_next = 32'd0;
      tok_row_next = 16'd1;
      tok_col_next = 16'd1;
      tok_off_next = 32'd0;
      tok_len_next = 16'd0;
    end

    if (n_res == 2'd1) begin
      res0.last = 1'b1;
    end
    if (n_res == 2'd2) begin
      res1.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= slex_pkg::MODE_IDLE;
      cur_row <= 16'd1;
      cur_col <= 16'd1;
      cur_off <= 32'd0;
      tok_row <= 16'd1;
      tok_col <= 16'd1;
      tok_off <= 32'd0;
      tok_len <= 16'd0;
    end else if (in_acc) begin
      mode    <= mode_next;
      cur_row <= cur_row_next;
      cur_col <= cur_col_next;
      cur_off <= cur_off_next;
      tok_row <= tok_row_next;
      tok_col <= tok_col_next;
      tok_off <= tok_off_next;
      tok_len <= tok_len_next;
    end
  end

  // Only the bytes of the current identifier are ever compared.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      word_buf <= word_buf_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && n_res != 2'd0) begin
      q[wr_ptr] <= res0;
      if (n_res == 2'd2) begin
        q[wr_ptr + 1'b1] <= res1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (in_acc) begin
        wr_ptr <= wr_ptr + slex_pkg::FIFO_PTR_W'(n_res);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (in_acc ? slex_pkg::FIFO_CNT_W'(n_res) : '0)
                     - slex_pkg::FIFO_CNT_W'(pop);
    end
  end

endmodule

### design/slex_checker.sv
// ---------------------------------------------------------------------------
// Lexer port checker
// Watches the core's ports for token properties that must always hold.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module slex_checker (
  input logic        clk,
  input logic        rst,
  input logic [7:0]  ch,
  input logic        in_valid,
  input logic        in_stall,
  input logic [2:0]  token_class,
  input logic [7:0]  token_value,
  input logic [15:0] start_row,
  input logic [15:0] start_col,
  input logic [31:0] start_offset,
  input logic [15:0] token_length,
  input logic        last,
  input logic        out_valid,
  input logic        out_stall
);

  // A waiting item must hold until it is taken.
  `SLEX_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(token_class) && $stable(start_offset) && $stable(last), "output item changed while stalled")

  // The end token has no text and closes the results of its byte.
  `SLEX_ASSERT_IMP(a_end_shape, out_valid && token_class == slex_pkg::CLS_END, token_length == 16'd0 && last && token_value == 8'd0, "malformed end token")

  // An unclosed string is always followed by the end token of the same byte.
  `SLEX_ASSERT_IMP(a_unterm_not_last, out_valid && token_class == slex_pkg::CLS_UNTERM, !last, "unterminated string marked last")

  // Punctuation is a single byte and is the last result of its byte.
  `SLEX_ASSERT_IMP(a_punct_shape, out_valid && token_class == slex_pkg::CLS_PUNCT, token_length == 16'd1 && last, "malformed punctuation token")

  // Keyword indexes stay within the keyword list.
  `SLEX_ASSERT_IMP(a_kw_index, out_valid && token_class == slex_pkg::CLS_KEYWORD, token_value < 8'(slex_pkg::KW_COUNT), "keyword index out of range")

endmodule

bind source_lexer_with_keywords_core slex_checker u_slex_checker (.*);
